// ===== rtl/ass_uue_pkg.sv =====
package ass_uue_pkg;

  // Characters per output line before a newline is owed.
  localparam int LineChars = 80;
  // Line counter width: holds 0..LineChars.
  localparam int LcW = $clog2(LineChars + 1);

  localparam int CharW   = 7;
  localparam int SixW    = 6;
  localparam int MaxRes  = 3;
  localparam int CntW    = 2;

  localparam logic [CharW-1:0] CharOfs     = 7'd33;
  localparam logic [CharW-1:0] CharNewline = 7'd10;

  // Position of the next byte within its three-byte group.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  // One output character with its end-of-data flag.
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             send;
  } beat_t;

  // All characters caused by one input byte; slot 0 goes out first.
  typedef struct packed {
    beat_t [MaxRes-1:0] beats;
    logic  [CntW-1:0]   cnt;
  } res_t;

endpackage

// ===== rtl/ass_uuencode_stream.sv =====
// Streaming six-bit text encoder for embedded font data.
// Input channel (s_axis): one data byte per beat in tdata[7:0]; tlast marks
// the last byte of the data. The byte after a tlast beat starts a new stream.
// Output channel (m_axis): one character per beat in tdata[6:0] (33..96, or
// 10 for a newline); tlast marks the last character caused by an input byte,
// tuser marks the last character of the whole encoded data.
// Configuration: cfg_we_i writes cfg_wdata_i into the line-break enable
// (reset 1); write it only while the block is idle.
// The first character of a byte reaches m_axis through the input register and
// then the result buffer.
// Throughput: one character per cycle while m_axis_tready is high; a byte
// produces one to three characters. The single output port of the result
// buffer sets this rate.
// The block takes a new byte while the previous byte's characters are still
// waiting: the input register holds it until the result buffer drains.
// Stall: when m_axis_tready is low the current character holds, the input
// register fills and then s_axis_tready drops; nothing is lost.
// Reset: group phase, carry, line count and owed newline clear, buffers empty.
module ass_uuencode_stream (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] stream_end
);
  import ass_uue_pkg::*;

  logic       line_breaks_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_final_q;
  logic       buf_free;
  logic       load;
  logic       accept;
  res_t       res;

  // Move the held byte into the result buffer once the buffer frees up.
  assign load          = in_valid_q && buf_free;
  assign s_axis_tready = !in_valid_q || load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_breaks_q <= 1'b1;
    end else if (cfg_we_i) begin
      line_breaks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q  <= s_axis_tdata;
      in_final_q <= s_axis_tlast;
    end
  end

  ass_uue_enc u_enc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .byte_i        (in_byte_q),
    .final_i       (in_final_q),
    .line_breaks_i (line_breaks_q),
    .res_o         (res)
  );

  ass_uue_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .res_i         (res),
    .free_o        (buf_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("end of data not on last beat of its byte");

  a_newline_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6:0] == CharNewline |-> !m_axis_tlast && !m_axis_tuser)
    else $error("newline closed a byte's output");

  a_hold_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !load |=> in_valid_q && $stable(in_byte_q))
    else $error("held input byte lost");

endmodule

// ===== rtl/ass_uue_enc.sv =====
module ass_uue_enc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [7:0]           byte_i,
  input  logic                 final_i,
  input  logic                 line_breaks_i,
  output ass_uue_pkg::res_t    res_o
);
  import ass_uue_pkg::*;

  typedef struct packed {
    logic [LcW-1:0] lc;
    logic           np;
  } line_t;

  phase_e         phase_q, phase_d;
  logic [3:0]     carry_q, carry_d;
  logic [LcW-1:0] lc_q, lc_d;
  logic           np_q, np_d;

  // When line breaks are on, count one character and raise the newline flag at a full line.
  function automatic line_t count_char(line_t cur, logic on);
    line_t          nxt;
    logic [LcW-1:0] inc;
    nxt = cur;
    inc = cur.lc + LcW'(1);
    if (on) begin
      if (inc >= LcW'(LineChars)) begin
        nxt.lc = '0;
        nxt.np = 1'b1;
      end else begin
        nxt.lc = inc;
      end
    end
    return nxt;
  endfunction

  function automatic beat_t enc_char(logic [SixW-1:0] six, logic send);
    beat_t b;
    b.ch   = CharW'(six) + CharOfs;
    b.send = send;
    return b;
  endfunction

  always_comb begin
    line_t ln;
    res_t  r;
    ln       = '{lc: lc_q, np: np_q};
    r        = '0;
    phase_d  = phase_q;
    carry_d  = carry_q;
    unique case (phase_q)
      PH_SECOND: begin
        r.beats[0] = enc_char({carry_q[1:0], byte_i[7:4]}, 1'b0);
        ln         = count_char(ln, line_breaks_i);
        if (final_i) begin
          r.beats[1] = enc_char({byte_i[3:0], 2'b00}, 1'b1);
          r.cnt      = CntW'(2);
        end else begin
          r.cnt      = CntW'(1);
          carry_d    = byte_i[3:0];
          phase_d    = PH_THIRD;
        end
      end
      PH_THIRD: begin
        r.beats[0] = enc_char({carry_q, byte_i[7:6]}, 1'b0);
        ln         = count_char(ln, line_breaks_i);
        r.beats[1] = enc_char(byte_i[5:0], final_i);
        ln         = count_char(ln, line_breaks_i);
        r.cnt      = CntW'(2);
        carry_d    = '0;
        phase_d    = PH_FIRST;
      end
      default: begin
        // Group start; the unused phase code behaves the same way.
        if (np_q) begin
          ln.np      = 1'b0;
          r.beats[0] = '{ch: CharNewline, send: 1'b0};
          r.beats[1] = enc_char(byte_i[7:2], 1'b0);
          ln         = count_char(ln, line_breaks_i);
          if (final_i) begin
            r.beats[2] = enc_char({byte_i[1:0], 4'b0000}, 1'b1);
            r.cnt      = CntW'(3);
          end else begin
            r.cnt      = CntW'(2);
          end
        end else begin
          r.beats[0] = enc_char(byte_i[7:2], 1'b0);
          ln         = count_char(ln, line_breaks_i);
          if (final_i) begin
            r.beats[1] = enc_char({byte_i[1:0], 4'b0000}, 1'b1);
            r.cnt      = CntW'(2);
          end else begin
            r.cnt      = CntW'(1);
          end
        end
        carry_d = {2'b00, byte_i[1:0]};
        phase_d = PH_SECOND;
      end
    endcase
    lc_d = ln.lc;
    np_d = ln.np;
    // End of data: drop any owed newline and restart the stream.
    if (final_i) begin
      phase_d = PH_FIRST;
      carry_d = '0;
      lc_d    = '0;
      np_d    = 1'b0;
    end
    res_o = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      carry_q <= '0;
      lc_q    <= '0;
      np_q    <= 1'b0;
    end else if (load_i) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
      lc_q    <= lc_d;
      np_q    <= np_d;
    end
  end

  a_lc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lc_q < LcW'(LineChars))
    else $error("line count reached a full line without wrapping");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && final_i |=> lc_q == '0 && !np_q && phase_q == PH_FIRST)
    else $error("state not cleared after last byte");

  a_newline_only_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    np_q && load_i && phase_q == PH_FIRST |-> res_o.beats[0].ch == CharNewline)
    else $error("owed newline not emitted at group start");

endmodule

// ===== rtl/ass_uue_ser.sv =====
module ass_uue_ser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  ass_uue_pkg::res_t       res_i,
  output logic                    free_o,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [7:0]              m_axis_tdata,
  output logic                    m_axis_tlast,
  output logic                    m_axis_tuser
);
  import ass_uue_pkg::*;

  beat_t [MaxRes-1:0] beats_q;
  logic  [CntW-1:0]   cnt_q;
  logic               take;

  assign m_axis_tvalid = (cnt_q != '0);
  assign take          = m_axis_tvalid && m_axis_tready;
  assign free_o        = (cnt_q == '0) || (take && cnt_q == CntW'(1));

  assign m_axis_tdata  = {1'b0, beats_q[0].ch};
  assign m_axis_tlast  = (cnt_q == CntW'(1));
  assign m_axis_tuser  = beats_q[0].send;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= res_i.cnt;
    end else if (take) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Shift the queue down one slot per delivered beat.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      beats_q <= res_i.beats;
    end else if (take) begin
      beats_q <= {beat_t'('0), beats_q[MaxRes-1:1]};
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o && res_i.cnt != '0)
    else $error("result buffer overwritten");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxRes))
    else $error("result count out of range");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !load_i |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("beat count did not advance");

endmodule
